@@ rtl/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants for the MIDI track event parser: the byte and event
// item layouts, status codes, event kinds and error codes.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Item taken on the byte channel
    typedef struct packed {
        logic [7:0] byte_in;
        logic       track_start;
    } mtep_in_t;

    // Item delivered on the event channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delta_time;
        logic [7:0]  status_byte;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] payload_length;
        logic [7:0]  payload_value;
        logic        last_payload;
        logic [1:0]  error_code;
    } mtep_out_t;

    // Byte fields
    localparam logic [7:0] STATUS_FLAG = 8'h80;
    localparam logic [7:0] DATA_MASK   = 8'h7f;
    localparam logic [7:0] HIGH_NIBBLE = 8'hf0;

    // Status codes with special handling
    localparam logic [7:0] ST_SYSEX     = 8'hf0;
    localparam logic [7:0] ST_SONG_POS  = 8'hf2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hf3;
    localparam logic [7:0] ST_TUNE_REQ  = 8'hf6;
    localparam logic [7:0] ST_ESC_SYSEX = 8'hf7;
    localparam logic [7:0] ST_META      = 8'hff;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_CTRL_CHG  = 8'hb0;
    localparam logic [7:0] ST_PITCH     = 8'he0;

    // Event kinds
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_SYSTEM  = 2'd1;
    localparam logic [1:0] KIND_HEADER  = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN    = 2'd2;
    localparam logic [1:0] ERR_SONG_SEL   = 2'd3;

endpackage

@@ rtl/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses the event bytes of a standard MIDI file track into channel, system
// common, sysex/meta header and payload byte items.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_ready/byte_item) takes one track byte per
//   item; track_start on the first byte of a track clears running status and
//   the parser before that byte is decoded as a delta byte.
//   Event channel (evt_valid/evt_ready/evt_item) gives zero or one item per
//   byte: events once their last byte is in, a header once a sysex/meta length
//   is complete, then one item per payload byte with last_payload on the end.
//   A byte is decoded out of the input register, and its item is written to
//   the event register once that register is free, which raises evt_valid.
//   Throughput: one byte per cycle while the receiver keeps up; parser state
//   is a single register set updated by one level of decode logic.
//   Reset clears all parser state and both valid flags; a byte or item still
//   in flight is dropped.
//   When the receiver stalls with an item pending, the input register holds
//   one more byte and byte_ready drops until the event register frees up.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  mtep_pkg::mtep_in_t  byte_item,
    output logic                evt_valid,
    input  logic                evt_ready,
    output mtep_pkg::mtep_out_t evt_item
);
    import mtep_pkg::*;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_LEN,
        PH_PAYLOAD
    } phase_t;

    function automatic logic is_channel(input logic [7:0] s);
        return s[7] && ((s & HIGH_NIBBLE) != HIGH_NIBBLE);
    endfunction

    function automatic logic two_data(input logic [7:0] s);
        logic [7:0] t;
        t = s & HIGH_NIBBLE;
        return (t >= ST_NOTE_OFF && t <= ST_CTRL_CHG) || t == ST_PITCH || s == ST_SONG_POS;
    endfunction

    // Item for a completed channel or system common message
    function automatic mtep_out_t finish_item(input logic [7:0]  st,
                                              input logic [7:0]  d1,
                                              input logic [7:0]  d2,
                                              input logic [31:0] delta);
        mtep_out_t r;
        r = '0;
        r.delta_time  = delta;
        r.status_byte = st;
        if (is_channel(st)) begin
            r.kind        = KIND_CHANNEL;
            r.first_data  = d1;
            r.second_data = d2;
        end else if (st == ST_SONG_SEL) begin
            r.kind       = KIND_SYSTEM;
            r.first_data = d1 & DATA_MASK;
            r.error_code = d1[7] ? ERR_SONG_SEL : ERR_NONE;
        end else begin
            r.kind        = KIND_SYSTEM;
            r.first_data  = d1;
            r.second_data = d2;
        end
        return r;
    endfunction

    // Input register
    logic      stage_valid_reg;
    mtep_in_t  stage_item_reg;

    // Parser state
    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] held_delta_reg, held_delta_next;
    logic [7:0]  running_reg, running_next;
    logic [7:0]  current_reg, current_next;
    logic [7:0]  held_first_reg, held_first_next;
    logic [31:0] bytes_left_reg, bytes_left_next;

    // Event register
    logic      evt_valid_reg;
    mtep_out_t evt_item_reg;

    logic        out_free;
    logic        advance;
    logic        res_valid;
    mtep_out_t   res;

    phase_t      ph_cur;
    logic [31:0] acc_cur, hd_cur, bl_cur;
    logic [7:0]  rs_cur, cs_cur, hfd_cur;
    logic [7:0]  b;
    logic [7:0]  st_sel;
    logic [7:0]  hdr;
    logic [31:0] acc_shift;
    logic [31:0] bl_dec;

    assign out_free   = !evt_valid_reg || evt_ready;
    assign advance    = stage_valid_reg && out_free;
    assign byte_ready = !stage_valid_reg || out_free;
    assign evt_valid  = evt_valid_reg;
    assign evt_item   = evt_item_reg;

    always_comb
    begin
        b = stage_item_reg.byte_in;
        // track_start clears state before the byte is decoded
        if (stage_item_reg.track_start) begin
            ph_cur  = PH_DELTA;
            acc_cur = '0;
            hd_cur  = '0;
            rs_cur  = '0;
            cs_cur  = '0;
            hfd_cur = '0;
            bl_cur  = '0;
        end else begin
            ph_cur  = phase_reg;
            acc_cur = acc_reg;
            hd_cur  = held_delta_reg;
            rs_cur  = running_reg;
            cs_cur  = current_reg;
            hfd_cur = held_first_reg;
            bl_cur  = bytes_left_reg;
        end

        acc_shift = {acc_cur[24:0], b[6:0]};
        bl_dec    = bl_cur - 32'd1;
        hdr       = (cs_cur == ST_META) ? hfd_cur : 8'd0;
        st_sel    = (ph_cur == PH_STATUS) ? rs_cur : cs_cur;

        phase_next      = ph_cur;
        acc_next        = acc_cur;
        held_delta_next = hd_cur;
        running_next    = rs_cur;
        current_next    = cs_cur;
        held_first_next = hfd_cur;
        bytes_left_next = bl_cur;

        res_valid      = 1'b0;
        res            = '0;
        res.delta_time = hd_cur;

        unique case (ph_cur)
            PH_DELTA:
            begin
                acc_next = acc_shift;
                if (!b[7]) begin
                    held_delta_next = acc_shift;
                    acc_next        = '0;
                    phase_next      = PH_STATUS;
                end
            end
            PH_STATUS, PH_DATA1:
            begin
                if (ph_cur == PH_STATUS && b[7]) begin
                    current_next    = b;
                    held_first_next = '0;
                    acc_next        = '0;
                    if (is_channel(b)) begin
                        running_next = b;
                        phase_next   = PH_DATA1;
                    end else if (b == ST_SYSEX || b == ST_ESC_SYSEX) begin
                        phase_next = PH_LEN;
                    end else if (b == ST_META) begin
                        phase_next = PH_MTYPE;
                    end else if (b == ST_SONG_POS || b == ST_SONG_SEL) begin
                        phase_next = PH_DATA1;
                    end else begin
                        phase_next      = PH_DELTA;
                        res_valid       = 1'b1;
                        res.kind        = KIND_SYSTEM;
                        res.status_byte = b;
                        res.error_code  = (b == ST_TUNE_REQ) ? ERR_NONE : ERR_UNKNOWN;
                    end
                end else if (ph_cur == PH_STATUS && rs_cur == 8'd0) begin
                    // stray data byte: report it, then it is the next delta
                    res_valid       = 1'b1;
                    res.kind        = KIND_SYSTEM;
                    res.error_code  = ERR_NO_RUNNING;
                    held_delta_next = {24'd0, b};
                    acc_next        = '0;
                end else begin
                    current_next    = st_sel;
                    held_first_next = (ph_cur == PH_STATUS) ? 8'd0 : hfd_cur;
                    if (two_data(st_sel)) begin
                        held_first_next = b;
                        phase_next      = PH_DATA2;
                    end else begin
                        phase_next = PH_DELTA;
                        res_valid  = 1'b1;
                        res        = finish_item(st_sel, b, 8'd0, hd_cur);
                    end
                end
            end
            PH_DATA2:
            begin
                phase_next = PH_DELTA;
                res_valid  = 1'b1;
                res        = finish_item(cs_cur, hfd_cur, b, hd_cur);
            end
            PH_MTYPE:
            begin
                held_first_next = b;
                acc_next        = '0;
                phase_next      = PH_LEN;
            end
            PH_LEN:
            begin
                acc_next = acc_shift;
                if (!b[7]) begin
                    bytes_left_next    = acc_shift;
                    phase_next         = (acc_shift != 32'd0) ? PH_PAYLOAD : PH_DELTA;
                    held_first_next    = hdr;
                    res_valid          = 1'b1;
                    res.kind           = KIND_HEADER;
                    res.status_byte    = cs_cur;
                    res.first_data     = hdr;
                    res.payload_length = acc_shift;
                end
            end
            PH_PAYLOAD:
            begin
                // acc holds the declared length during the payload
                bytes_left_next    = bl_dec;
                res_valid          = 1'b1;
                res.kind           = KIND_PAYLOAD;
                res.status_byte    = cs_cur;
                res.first_data     = hfd_cur;
                res.payload_length = acc_cur;
                res.payload_value  = b;
                res.last_payload   = (bl_dec == 32'd0);
                if (bl_dec == 32'd0) begin
                    acc_next   = '0;
                    phase_next = PH_DELTA;
                end
            end
            default:
            begin
                phase_next      = PH_DELTA;
                acc_next        = '0;
                held_delta_next = '0;
                running_next    = '0;
                current_next    = '0;
                held_first_next = '0;
                bytes_left_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            evt_valid_reg   <= 1'b0;
            phase_reg       <= PH_DELTA;
            acc_reg         <= '0;
            held_delta_reg  <= '0;
            running_reg     <= '0;
            current_reg     <= '0;
            held_first_reg  <= '0;
            bytes_left_reg  <= '0;
        end else begin
            if (byte_ready) begin
                stage_valid_reg <= byte_valid;
            end
            if (advance) begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                held_delta_reg <= held_delta_next;
                running_reg    <= running_next;
                current_reg    <= current_next;
                held_first_reg <= held_first_next;
                bytes_left_reg <= bytes_left_next;
            end
            if (advance && res_valid) begin
                evt_valid_reg <= 1'b1;
            end else if (evt_ready) begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid) begin
            stage_item_reg <= byte_item;
        end
        if (advance && res_valid) begin
            evt_item_reg <= res;
        end
    end

`ifndef ASSERT_OFF
    // a payload item always belongs to a message with a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.kind == KIND_PAYLOAD |-> evt_item.payload_length != 32'd0)
        else $error("payload item with zero length");

    // payload phase never runs with nothing left to deliver
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> bytes_left_reg != 32'd0)
        else $error("payload phase with no bytes left");

    // running status only ever holds a channel status
    assert property (@(posedge clk) disable iff (!rst_n)
        running_reg == 8'd0 || is_channel(running_reg))
        else $error("running status holds a non-channel status");

    // a stray data byte error carries no status
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_item.error_code == ERR_NO_RUNNING |-> evt_item.status_byte == 8'd0)
        else $error("no-running-status error with a status byte");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the MIDI track event parser against a predictor of its own. Short
// directed tests hit delta wrap, missing running status, song select, system
// statuses and payload lengths at both ends. A random stream of mostly
// well-formed events with some noise follows. The sender and the receiver
// both stall at random.
// ----------------------------------------------------------------------------
module tb;
    import mtep_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 650;
    localparam int PRINT_LIMIT = 100;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_MTYPE,
        PH_LEN,
        PH_PAYLOAD
    } parse_phase_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_ready;
    mtep_in_t  byte_item = '0;
    logic      evt_valid;
    logic      evt_ready = 1'b0;
    mtep_out_t evt_item;

    // parser state as predicted
    parse_phase_t cur_phase = PH_DELTA;
    logic [31:0]  acc = '0;
    logic [31:0]  delta_hold = '0;
    logic [7:0]   run_status = '0;
    logic [7:0]   cur_status = '0;
    logic [7:0]   first_hold = '0;
    logic [31:0]  remaining = '0;

    mtep_out_t pending_events[$];
    int        mismatch_count = 0;
    int        bytes_sent = 0;
    int        idle_cycles = 0;
    int        tx_idle_pct = 22;
    int        rx_idle_pct = 55;

    // stimulus-side view of the stream
    logic [7:0] gen_running = '0;
    bit         gen_resync = 1'b1;

    midi_track_event_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt_item   (evt_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit is_channel_status(input logic [7:0] s);
        return (s >= STATUS_FLAG) && (s < ST_SYSEX);
    endfunction

    function automatic bit has_two_data(input logic [7:0] s);
        logic [7:0] t;
        t = s & HIGH_NIBBLE;
        return (t >= ST_NOTE_OFF && t <= ST_CTRL_CHG) || t == ST_PITCH || s == ST_SONG_POS;
    endfunction

    function automatic mtep_out_t make_event(input logic [1:0] kind, input logic [7:0] st,
                                             input logic [7:0] d1, input logic [7:0] d2,
                                             input logic [31:0] len, input logic [7:0] pv,
                                             input logic last, input logic [1:0] err);
        mtep_out_t ev;
        ev.kind           = kind;
        ev.delta_time     = delta_hold;
        ev.status_byte    = st;
        ev.first_data     = d1;
        ev.second_data    = d2;
        ev.payload_length = len;
        ev.payload_value  = pv;
        ev.last_payload   = last;
        ev.error_code     = err;
        return ev;
    endfunction

    task automatic queue_event(input mtep_out_t ev);
        pending_events = {pending_events, ev};
    endtask

    task automatic clear_parser();
        cur_phase  = PH_DELTA;
        acc        = '0;
        delta_hold = '0;
        run_status = '0;
        cur_status = '0;
        first_hold = '0;
        remaining  = '0;
    endtask

    task automatic complete_message(input logic [7:0] d1, input logic [7:0] d2);
        cur_phase = PH_DELTA;
        if (is_channel_status(cur_status))
            queue_event(make_event(KIND_CHANNEL, cur_status, d1, d2,
                                   32'd0, 8'd0, 1'b0, ERR_NONE));
        else if (cur_status == ST_SONG_SEL)
            queue_event(make_event(KIND_SYSTEM, cur_status, d1 & DATA_MASK, 8'd0,
                                   32'd0, 8'd0, 1'b0,
                                   d1[7] ? ERR_SONG_SEL : ERR_NONE));
        else
            queue_event(make_event(KIND_SYSTEM, cur_status, d1, d2,
                                   32'd0, 8'd0, 1'b0, ERR_NONE));
    endtask

    task automatic take_first_data(input logic [7:0] b);
        if (has_two_data(cur_status))
        begin
            first_hold = b;
            cur_phase  = PH_DATA2;
        end
        else
            complete_message(b, 8'd0);
    endtask

    task automatic decode_track_byte(input mtep_in_t it);
        logic [7:0] b;
        logic [7:0] hdr;
        b = it.byte_in;
        if (it.track_start)
            clear_parser();
        case (cur_phase)
            PH_DELTA:
            begin
                acc = {acc[24:0], b[6:0]};
                if (!b[7])
                begin
                    delta_hold = acc;
                    acc        = '0;
                    cur_phase  = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (b[7])
                begin
                    cur_status = b;
                    first_hold = '0;
                    acc        = '0;
                    if (is_channel_status(b))
                    begin
                        run_status = b;
                        cur_phase  = PH_DATA1;
                    end
                    else if (b == ST_SYSEX || b == ST_ESC_SYSEX)
                        cur_phase = PH_LEN;
                    else if (b == ST_META)
                        cur_phase = PH_MTYPE;
                    else if (b == ST_SONG_POS || b == ST_SONG_SEL)
                        cur_phase = PH_DATA1;
                    else
                    begin
                        cur_phase = PH_DELTA;
                        queue_event(make_event(KIND_SYSTEM, b, 8'd0, 8'd0,
                            32'd0, 8'd0, 1'b0, (b == ST_TUNE_REQ) ? ERR_NONE : ERR_UNKNOWN));
                    end
                end
                else if (run_status == 8'd0)
                begin
                    // orphan data byte: flagged, then reused as the next delta
                    queue_event(make_event(KIND_SYSTEM, 8'd0, 8'd0, 8'd0,
                                           32'd0, 8'd0, 1'b0, ERR_NO_RUNNING));
                    delta_hold = {24'd0, b};
                    acc        = '0;
                end
                else
                begin
                    cur_status = run_status;
                    first_hold = '0;
                    take_first_data(b);
                end
            end
            PH_DATA1:
                take_first_data(b);
            PH_DATA2:
                complete_message(first_hold, b);
            PH_MTYPE:
            begin
                first_hold = b;
                acc        = '0;
                cur_phase  = PH_LEN;
            end
            PH_LEN:
            begin
                acc = {acc[24:0], b[6:0]};
                if (!b[7])
                begin
                    remaining = acc;
                    cur_phase = (remaining != 0) ? PH_PAYLOAD : PH_DELTA;
                    hdr = (cur_status == ST_META) ? first_hold : 8'd0;
                    queue_event(make_event(KIND_HEADER, cur_status, hdr, 8'd0,
                                           remaining, 8'd0, 1'b0, ERR_NONE));
                    first_hold = hdr;
                    // length stays in the accumulator for the payload items
                    acc = remaining;
                end
            end
            PH_PAYLOAD:
            begin
                remaining = remaining - 1;
                queue_event(make_event(KIND_PAYLOAD, cur_status, first_hold, 8'd0,
                                       acc, b, remaining == 0, ERR_NONE));
                if (remaining == 0)
                begin
                    acc       = '0;
                    cur_phase = PH_DELTA;
                end
            end
            default:
                clear_parser();
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && byte_ready)
            decode_track_byte(byte_item);
    end

    always @(posedge clk)
    begin
        mtep_out_t want;
        if (rst_n && evt_valid && evt_ready)
        begin
            if (pending_events.size() == 0)
                report_mismatch($sformatf("event item with nothing pending, kind %0d",
                                          evt_item.kind));
            else
            begin
                want = pending_events.pop_front();
                check_field("kind", 32'(evt_item.kind), 32'(want.kind));
                check_field("delta_time", evt_item.delta_time, want.delta_time);
                check_field("status_byte", 32'(evt_item.status_byte),
                            32'(want.status_byte));
                check_field("first_data", 32'(evt_item.first_data),
                            32'(want.first_data));
                check_field("second_data", 32'(evt_item.second_data),
                            32'(want.second_data));
                check_field("payload_length", evt_item.payload_length, want.payload_length);
                check_field("payload_value", 32'(evt_item.payload_value),
                            32'(want.payload_value));
                check_field("last_payload", 32'(evt_item.last_payload),
                            32'(want.last_payload));
                check_field("error_code", 32'(evt_item.error_code),
                            32'(want.error_code));
            end
        end
    end

    always @(posedge clk)
        evt_ready <= ($urandom_range(99) >= rx_idle_pct);

    // nothing accepted on either side for too long
    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (evt_valid && evt_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit ts);
        mtep_in_t it;
        it.byte_in     = b;
        it.track_start = ts;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // variable-length value, optionally led by junk/padding groups
    task automatic send_vlq(input logic [31:0] v, input int extra, input bit ts);
        int  groups;
        bit  first;
        logic [7:0] b;
        groups = 1;
        first  = ts;
        while (groups < 5 && (v >> (7 * groups)) != 0)
            groups++;
        for (int i = 0; i < extra; i++)
        begin
            b = STATUS_FLAG | (($urandom_range(99) < 50) ? 8'd0 : 8'($urandom_range(127)));
            send_byte(b, first);
            first = 1'b0;
        end
        for (int k = groups - 1; k >= 0; k--)
        begin
            b = 8'((v >> (7 * k)) & 32'h7f);
            if (k != 0)
                b = b | STATUS_FLAG;
            send_byte(b, first);
            first = 1'b0;
        end
    endtask

    task automatic send_data_bytes(input logic [7:0] st);
        int n;
        int high_pct;
        n = has_two_data(st) ? 2 : 1;
        high_pct = (st == ST_SONG_SEL) ? 30 : 10;
        for (int i = 0; i < n; i++)
            send_byte(($urandom_range(99) < high_pct) ? 8'($urandom_range(255))
                                                       : 8'($urandom_range(127)), 1'b0);
    endtask

    task automatic send_payload(input logic [31:0] len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_random_event(input bit force_start);
        int          pick;
        int          r;
        int          extra;
        bit          ts;
        logic [31:0] dv;
        logic [31:0] len;
        logic [7:0]  st;
        pick = $urandom_range(99);
        // an orphan data byte needs running status cleared
        ts = force_start || (pick >= 87 && pick < 92) || ($urandom_range(99) < 4);
        if (ts)
            gen_running = '0;
        gen_resync = 1'b0;
        extra = ($urandom_range(99) < 8) ? $urandom_range(3, 1) : 0;
        r = $urandom_range(99);
        if (r < 60)
            dv = $urandom_range(127);
        else if (r < 85)
            dv = $urandom_range(16383);
        else if (r < 95)
            dv = $urandom_range(2097151);
        else
            dv = $urandom;
        send_vlq(dv, extra, ts);

        if (pick < 35 || (pick < 55 && gen_running == 8'd0))
        begin
            st = 8'($urandom_range(8'hef, 8'h80));
            send_byte(st, 1'b0);
            gen_running = st;
            send_data_bytes(st);
        end
        else if (pick < 55)
            send_data_bytes(gen_running);
        else if (pick < 65)
        begin
            r = $urandom_range(3);
            case (r)
                0:       st = ST_SONG_POS;
                1:       st = ST_SONG_SEL;
                2:       st = ST_TUNE_REQ;
                default:
                begin
                    st = 8'($urandom_range(8'hfe, 8'hf1));
                    if (st == ST_SONG_POS || st == ST_SONG_SEL || st == ST_TUNE_REQ
                        || st == ST_ESC_SYSEX)
                        st = 8'hf4;
                end
            endcase
            send_byte(st, 1'b0);
            if (st == ST_SONG_POS || st == ST_SONG_SEL)
                send_data_bytes(st);
        end
        else if (pick < 75)
        begin
            st  = ($urandom_range(1) == 0) ? ST_SYSEX : ST_ESC_SYSEX;
            len = ($urandom_range(99) < 10) ? 32'd0 : 32'($urandom_range(6));
            send_byte(st, 1'b0);
            send_vlq(len, ($urandom_range(99) < 10) ? 1 : 0, 1'b0);
            send_payload(len);
        end
        else if (pick < 87)
        begin
            len = ($urandom_range(99) < 15) ? 32'd0 : 32'($urandom_range(6));
            send_byte(ST_META, 1'b0);
            send_byte(8'($urandom_range(255)), 1'b0);
            send_vlq(len, 0, 1'b0);
            send_payload(len);
        end
        else if (pick < 92)
        begin
            // orphan byte becomes the delta; a full message follows
            send_byte(8'($urandom_range(127)), 1'b0);
            st = 8'($urandom_range(8'hef, 8'h80));
            send_byte(st, 1'b0);
            gen_running = st;
            send_data_bytes(st);
        end
        else if (pick < 96)
        begin
            // huge declared length, cut short by the next track start
            st  = ($urandom_range(1) == 0) ? ST_META : ST_SYSEX;
            len = ($urandom_range(1) == 0) ? 32'hffffffff : $urandom;
            send_byte(st, 1'b0);
            if (st == ST_META)
                send_byte(8'($urandom_range(255)), 1'b0);
            send_vlq(len, 0, 1'b0);
            send_payload((len < 3) ? len : 32'($urandom_range(3)));
            gen_resync = 1'b1;
        end
        else
        begin
            r = $urandom_range(3, 1);
            for (int i = 0; i < r; i++)
                send_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
            gen_resync = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_missing_running_status();
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_channel_and_running();
        send_byte(ST_PITCH | 8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_delta_wrap_song_select();
        send_vlq(32'hffffffff, 0, 1'b0);
        send_byte(ST_SONG_SEL, 1'b0);
        send_byte(8'h85, 1'b0);
    endtask

    task automatic test_system_status();
        send_byte(8'h00, 1'b0);
        send_byte(8'hfd, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ST_TUNE_REQ, 1'b0);
    endtask

    task automatic test_meta_zero_length();
        send_byte(8'h00, 1'b0);
        send_byte(ST_META, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_max_length_abort();
        send_byte(8'h00, 1'b0);
        send_byte(ST_ESC_SYSEX, 1'b0);
        send_vlq(32'hffffffff, 0, 1'b0);
        send_byte(8'hab, 1'b0);
        gen_resync = 1'b1;
    endtask

    task automatic test_random_stream();
        while (bytes_sent < BYTE_TARGET)
        begin
            if (bytes_sent < BYTE_TARGET / 3)
            begin
                tx_idle_pct = 22;
                rx_idle_pct = 55;
            end
            else if (bytes_sent < 2 * BYTE_TARGET / 3)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 22;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_event(gen_resync);
        end
        byte_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_missing_running_status();
        test_channel_and_running();
        test_delta_wrap_song_select();
        test_system_status();
        test_meta_zero_length();
        test_max_length_abort();
        test_random_stream();

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", pending_events.size()));

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
